// File: design/drss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package drss_pkg;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 32;
  localparam logic [15:0] FullTurn = 16'd46080;
  localparam logic [15:0] QuarterTurn = 16'd11520;
  localparam logic [15:0] PeriodReset = 16'd655;
  localparam logic signed [24:0] GainQ24 = 25'sd10188014;
  localparam int unsigned PosW = 64;
  localparam int unsigned AngW = 34;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic signed [AngW-1:0] ang_t;

  function automatic ang_t atan_entry(input logic [4:0] i);
    ang_t v;
    begin
      case (i)
        5'd0: v = 34'sd2949120;
        5'd1: v = 34'sd1740967;
        5'd2: v = 34'sd919879;
        5'd3: v = 34'sd466945;
        5'd4: v = 34'sd234379;
        5'd5: v = 34'sd117305;
        5'd6: v = 34'sd58666;
        5'd7: v = 34'sd29335;
        5'd8: v = 34'sd14668;
        5'd9: v = 34'sd7334;
        5'd10: v = 34'sd3667;
        5'd11: v = 34'sd1833;
        5'd12: v = 34'sd917;
        5'd13: v = 34'sd458;
        5'd14: v = 34'sd229;
        5'd15: v = 34'sd115;
        5'd16: v = 34'sd57;
        5'd17: v = 34'sd29;
        5'd18: v = 34'sd14;
        5'd19: v = 34'sd7;
        5'd20: v = 34'sd4;
        5'd21: v = 34'sd2;
        5'd22: v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [2:0] pick_sector(input logic [15:0] b);
    logic [2:0] s;
    begin
      if (b > 16'd8640 && b <= 16'd14400) s = 3'd0;
      else if (b > 16'd2880 && b <= 16'd8640) s = 3'd1;
      else if (b <= 16'd2880 || b > 16'd43200) s = 3'd2;
      else if (b > 16'd37440) s = 3'd3;
      else if (b > 16'd31680) s = 3'd4;
      else if (b > 16'd25920) s = 3'd5;
      else if (b > 16'd20160) s = 3'd6;
      else s = 3'd7;
      return s;
    end
  endfunction

  typedef struct packed {
    logic start;
    logic vector_mode;
  } cordic_cmd_t;
endpackage
`default_nettype wire

// File: design/drss_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module drss_cordic #(
  parameter int unsigned CORDIC_STEPS = drss_pkg::CordicStepsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire drss_pkg::cordic_cmd_t cmd,
  input  wire drss_pkg::pos_t      x_in,
  input  wire drss_pkg::pos_t      y_in,
  input  wire drss_pkg::ang_t      z_in,
  output logic                     done,
  output drss_pkg::pos_t           x_out,
  output drss_pkg::pos_t           y_out,
  output drss_pkg::ang_t           z_out
);
  import drss_pkg::*;
  localparam int unsigned IW = $clog2(CORDIC_STEPS + 1);

  pos_t x_r, x_nxt, y_r, y_nxt;
  ang_t z_r, z_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, vec_r, vec_nxt, done_r, done_nxt;
  logic dir;
  pos_t xs, ys;
  ang_t a;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    a = atan_entry(5'(i_r));
    dir = vec_r ? !y_r[PosW-1] : !z_r[AngW-1];
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    i_nxt = i_r; busy_nxt = busy_r; vec_nxt = vec_r; done_nxt = 1'b0;
    if (cmd.start) begin
      x_nxt = x_in; y_nxt = y_in; z_nxt = z_in;
      i_nxt = '0; busy_nxt = 1'b1; vec_nxt = cmd.vector_mode;
    end else if (busy_r) begin
      if (dir == !vec_r) begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - a;
      end else begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + a;
      end
      if (vec_r) begin
        if (dir) z_nxt = z_r + a;
        else z_nxt = z_r - a;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == IW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; vec_r <= vec_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule
`default_nettype wire

// File: design/dead_reckoning_sector_select_top.sv
`timescale 1ns / 1ps
// Timing: a load transaction shows its result in the cycle after acceptance, a step
// transaction after the states DVX, DVY, DPX, DPY, ROT, GX, GY, VEC, MAG and FIN (VEC and
// MAG are skipped when the new position is the origin), using the shared CORDIC that runs
// rotation and then vectoring. Throughput: one transaction at a time; in_stall is high
// while busy, and the next transaction can be accepted once S_OUT is left with out_stall low.
// Reset: synchronous active-low rst_n clears the state and sets step_period to 655.
`default_nettype none
module dead_reckoning_sector_select_top #(
  parameter int unsigned CORDIC_STEPS = drss_pkg::CordicStepsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_action,
  input  wire logic signed [31:0] in_accel_x,
  input  wire logic signed [31:0] in_accel_y,
  input  wire logic [15:0]        in_fix_bearing,
  input  wire logic [31:0]        in_fix_range,
  input  wire logic [2:0]         in_fix_sector,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_bearing,
  output logic [31:0]             out_range,
  output logic [2:0]              out_sector,
  output logic signed [31:0]      out_vel_x,
  output logic signed [31:0]      out_vel_y
);
  import drss_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DVX   = 12'b000000000010,
    S_DVY   = 12'b000000000100,
    S_DPX   = 12'b000000001000,
    S_DPY   = 12'b000000010000,
    S_ROT   = 12'b000000100000,
    S_GX    = 12'b000001000000,
    S_GY    = 12'b000010000000,
    S_VEC   = 12'b000100000000,
    S_MAG   = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [15:0] per_r, head_r, head_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt, nvx_r, nvx_nxt, nvy_r, nvy_nxt;
  logic conv_r, conv_nxt;
  logic [2:0] sec_r, sec_nxt;
  logic signed [31:0] ay_r, ay_nxt;
  pos_t dpx_r, dpx_nxt, dpy_r, dpy_nxt, px_r, px_nxt;

  // Shared multiplier: signed 40 x 25 with registered product.
  logic signed [39:0] ma;
  logic signed [24:0] mb;
  logic signed [64:0] prod_r;
  logic signed [64:0] rnd16, rnd17, rnd24;

  cordic_cmd_t cmd;
  pos_t cx_in, cy_in, cx_o, cy_o;
  ang_t cz_in, cz_o;
  logic c_done;

  drss_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
    .done(c_done), .x_out(cx_o), .y_out(cy_o), .z_out(cz_o)
  );

  logic signed [33:0] dvs;
  logic [15:0] hconv, bq;
  ang_t zq, zw;
  logic signed [64:0] mag;
  logic [16:0] bsum;

  always_comb begin
    rnd16 = (prod_r + 65'sd32768) >>> 16;
    rnd17 = (prod_r + 65'sd65536) >>> 17;
    rnd24 = (prod_r + 65'sd8388608) >>> 24;
    ma = '0; mb = '0;
    case (st_r)
      S_IDLE:  begin ma = 40'(in_accel_x); mb = 25'($signed({1'b0, per_r})); end
      S_DVX:   begin ma = 40'(ay_r); mb = 25'($signed({1'b0, per_r})); end
      S_DVY:   begin ma = 40'(nvx_r) + 40'(vx_r);
                     mb = 25'($signed({1'b0, per_r})); end
      S_DPX:   begin ma = 40'(nvy_r) + 40'(vy_r);
                     mb = 25'($signed({1'b0, per_r})); end
      S_ROT:   begin ma = 40'(cx_o); mb = GainQ24; end
      S_GX:    begin ma = 40'(cy_o); mb = GainQ24; end
      S_VEC:   begin ma = 40'(cx_o); mb = GainQ24; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    st_nxt = st_r; head_nxt = head_r; dist_nxt = dist_r; vx_nxt = vx_r; vy_nxt = vy_r;
    nvx_nxt = nvx_r; nvy_nxt = nvy_r; conv_nxt = conv_r; sec_nxt = sec_r;
    ay_nxt = ay_r; dpx_nxt = dpx_r; dpy_nxt = dpy_r; px_nxt = px_r;
    cmd = '0; cx_in = '0; cy_in = '0; cz_in = '0;
    dvs = '0; hconv = '0; bq = '0; zq = '0; zw = '0; mag = '0; bsum = '0;
    case (st_r)
      S_IDLE: if (in_valid) begin
        if (in_action) begin
          head_nxt = (in_fix_bearing >= FullTurn) ? in_fix_bearing - FullTurn
                                                  : in_fix_bearing;
          dist_nxt = in_fix_range; sec_nxt = in_fix_sector; conv_nxt = 1'b1;
          st_nxt = S_OUT;
        end else begin
          ay_nxt = in_accel_y;
          if (conv_r) begin
            hconv = (head_r <= QuarterTurn) ? QuarterTurn - head_r
                                            : FullTurn + QuarterTurn - head_r;
            head_nxt = hconv;
          end
          conv_nxt = 1'b0;
          st_nxt = S_DVX;
        end
      end
      S_DVX: begin
        dvs = 34'(rnd16) + 34'(vx_r);
        nvx_nxt = (dvs > 34'sd2147483647) ? 32'sh7fffffff :
                  (dvs < -34'sd2147483648) ? 32'sh80000000 : 32'(dvs);
        st_nxt = S_DVY;
      end
      S_DVY: begin
        dvs = 34'(rnd16) + 34'(vy_r);
        nvy_nxt = (dvs > 34'sd2147483647) ? 32'sh7fffffff :
                  (dvs < -34'sd2147483648) ? 32'sh80000000 : 32'(dvs);
        nvx_nxt = nvx_r;
        st_nxt = S_DPX;
      end
      S_DPX: begin
        nvy_nxt = nvy_r;
        dpx_nxt = 64'(rnd17);
        st_nxt = S_DPY;
      end
      S_DPY: begin
        dpy_nxt = 64'(rnd17);
        zw = ang_t'({head_r, 9'd0});
        cx_in = 64'({32'd0, dist_r});
        if (zw > 34'sd5898240 && zw < 34'sd17694720) begin
          cx_in = -64'({32'd0, dist_r}); zw = zw - 34'sd11796480;
        end else if (zw >= 34'sd17694720) begin
          zw = zw - 34'sd23592960;
        end
        cz_in = zw; cmd.start = 1'b1; cmd.vector_mode = 1'b0;
        st_nxt = S_ROT;
      end
      S_ROT: if (c_done) st_nxt = S_GX;
      S_GX: begin
        px_nxt = 64'(rnd24) + dpx_r;
        st_nxt = S_GY;
      end
      S_GY: begin
        cx_in = px_r; cy_in = 64'(rnd24) + dpy_r;
        if (cx_in == '0 && cy_in == '0) begin
          head_nxt = '0; dist_nxt = '0; sec_nxt = 3'd2; st_nxt = S_FIN;
        end else begin
          cz_in = '0;
          if (cx_in[PosW-1]) begin
            cx_in = -cx_in; cy_in = -cy_in; cz_in = 34'sd11796480;
          end
          cmd.start = 1'b1; cmd.vector_mode = 1'b1;
          st_nxt = S_VEC;
        end
      end
      S_VEC: if (c_done) st_nxt = S_MAG;
      S_MAG: begin
        mag = rnd24;
        dist_nxt = (mag < 0) ? 32'd0 : (mag > 65'sd4294967295) ? 32'hffffffff : 32'(mag);
        zq = cz_o[AngW-1] ? cz_o + 34'sd23592960 : cz_o;
        bsum = 17'((zq + 34'sd256) >>> 9);
        bq = (bsum >= 17'(FullTurn)) ? 16'(bsum - 17'(FullTurn)) : 16'(bsum);
        head_nxt = bq; sec_nxt = pick_sector(bq);
        st_nxt = S_FIN;
      end
      S_FIN: begin
        vx_nxt = nvx_r; vy_nxt = nvy_r; st_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 65'(ma) * 65'(mb);
    ay_r <= ay_nxt; nvx_r <= nvx_nxt; nvy_r <= nvy_nxt;
    dpx_r <= dpx_nxt; dpy_r <= dpy_nxt; px_r <= px_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; per_r <= PeriodReset; head_r <= '0; dist_r <= '0;
      vx_r <= '0; vy_r <= '0; conv_r <= 1'b0; sec_r <= '0;
    end else begin
      st_r <= st_nxt; head_r <= head_nxt; dist_r <= dist_nxt; vx_r <= vx_nxt;
      vy_r <= vy_nxt; conv_r <= conv_nxt; sec_r <= sec_nxt;
      if (cfg_we) per_r <= cfg_wdata;
    end
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_bearing = head_r;
  assign out_range = dist_r;
  assign out_sector = sec_r;
  assign out_vel_x = vx_r;
  assign out_vel_y = vy_r;

`ifndef SYNTH
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bearing < FullTurn) else $error("bearing out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
`endif
endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import drss_pkg::*;

  typedef struct {
    logic [15:0] bearing;
    logic [31:0] range;
    logic [2:0]  sector;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } fix_state_t;

  localparam int unsigned NumSteps = 16;
  localparam longint unsigned CycleLimit = 3000000;

  class track_scoreboard;
    logic [15:0] period;
    logic [15:0] heading;
    logic [31:0] distance;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic convert;
    logic [2:0] sect;
    fix_state_t pending[$];
    int mismatches;
    int checked;

    function void clear();
      period = PeriodReset;
      heading = '0;
      distance = '0;
      vx = '0;
      vy = '0;
      convert = 1'b0;
      sect = '0;
      pending.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function longint floor_shift(longint x, int n);
      return x >>> n;
    endfunction

    function longint round_shift(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint atan_val(int i);
      longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
      return (i < 23) ? t[i] : 0;
    endfunction

    function logic signed [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function logic [2:0] sector_of(logic [15:0] b);
      if (b > 8640 && b <= 14400) return 3'd0;
      if (b > 2880 && b <= 8640) return 3'd1;
      if (b <= 2880 || b > 43200) return 3'd2;
      if (b > 37440) return 3'd3;
      if (b > 31680) return 3'd4;
      if (b > 25920) return 3'd5;
      if (b > 20160) return 3'd6;
      return 3'd7;
    endfunction

    function void advance(logic act, logic signed [31:0] ax, logic signed [31:0] ay,
                          logic [15:0] fb, logic [31:0] fr, logic [2:0] fs);
      longint per, x, y, z, nx, ny, mag;
      logic signed [31:0] nvx, nvy;
      fix_state_t e;
      if (act) begin
        heading = (fb >= FullTurn) ? fb - FullTurn : fb;
        distance = fr;
        sect = fs;
        convert = 1'b1;
      end else begin
        per = longint'(period);
        if (convert) begin
          heading = (heading <= QuarterTurn) ? QuarterTurn - heading
                                             : FullTurn + QuarterTurn - heading;
        end
        convert = 1'b0;
        nvx = clamp32(longint'(vx) + round_shift(longint'(ax) * per, 16));
        nvy = clamp32(longint'(vy) + round_shift(longint'(ay) * per, 16));
        z = longint'(heading) * 512;
        x = longint'(distance);
        y = 0;
        if (z > 90 * 65536 && z < 270 * 65536) begin
          x = -x;
          z -= 180 * 65536;
        end else if (z >= 270 * 65536) begin
          z -= 360 * 65536;
        end
        for (int i = 0; i < NumSteps; i++) begin
          if (z >= 0) begin
            nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= atan_val(i);
          end else begin
            nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += atan_val(i);
          end
          x = nx; y = ny;
        end
        x = round_shift(x * 10188014, 24);
        y = round_shift(y * 10188014, 24);
        x += round_shift((longint'(nvx) + longint'(vx)) * per, 17);
        y += round_shift((longint'(nvy) + longint'(vy)) * per, 17);
        if (x == 0 && y == 0) begin
          heading = 0;
          distance = 0;
        end else begin
          z = 0;
          if (x < 0) begin
            x = -x; y = -y; z = 180 * 65536;
          end
          for (int i = 0; i < NumSteps; i++) begin
            if (y >= 0) begin
              nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += atan_val(i);
            end else begin
              nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= atan_val(i);
            end
            x = nx; y = ny;
          end
          mag = round_shift(x * 10188014, 24);
          if (mag < 0) mag = 0;
          if (mag > 64'hFFFFFFFF) mag = 64'hFFFFFFFF;
          if (z < 0) z += 360 * 65536;
          z = (z + 256) >>> 9;
          if (z >= FullTurn) z -= FullTurn;
          heading = z[15:0];
          distance = mag[31:0];
        end
        sect = sector_of(heading);
        vx = nvx;
        vy = nvy;
      end
      e.bearing = heading;
      e.range = distance;
      e.sector = sect;
      e.vel_x = vx;
      e.vel_y = vy;
      pending.push_back(e);
    endfunction

    function void check_result(fix_state_t got);
      fix_state_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.bearing !== e.bearing || got.range !== e.range || got.sector !== e.sector
          || got.vel_x !== e.vel_x || got.vel_y !== e.vel_y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch at %0t: expected b=%0d r=%h s=%0d vx=%h vy=%h", $realtime,
                   e.bearing, e.range, e.sector, e.vel_x, e.vel_y);
          $display("                 actual   b=%0d r=%h s=%0d vx=%h vy=%h",
                   got.bearing, got.range, got.sector, got.vel_x, got.vel_y);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic signed [31:0] in_accel_x = '0;
  logic signed [31:0] in_accel_y = '0;
  logic [15:0] in_fix_bearing = '0;
  logic [31:0] in_fix_range = '0;
  logic [2:0] in_fix_sector = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_bearing;
  logic [31:0] out_range;
  logic [2:0] out_sector;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;

  track_scoreboard board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  longint unsigned cycles = 0;
  int sent = 0;

  dead_reckoning_sector_select_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y),
    .in_fix_bearing(in_fix_bearing), .in_fix_range(in_fix_range),
    .in_fix_sector(in_fix_sector), .out_valid(out_valid), .out_stall(out_stall),
    .out_bearing(out_bearing), .out_range(out_range), .out_sector(out_sector),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    fix_state_t got;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got.bearing = out_bearing;
      got.range = out_range;
      got.sector = out_sector;
      got.vel_x = out_vel_x;
      got.vel_y = out_vel_y;
      board.check_result(got);
    end
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(logic act, logic signed [31:0] ax, logic signed [31:0] ay,
                           logic [15:0] fb, logic [31:0] fr, logic [2:0] fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_fix_bearing <= fb;
    in_fix_range <= fr;
    in_fix_sector <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.advance(act, ax, ay, fb, fr, fs);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (2 * NumSteps + 30) @(negedge clk);
  endtask

  task automatic write_period(logic [15:0] p);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.period = p;
  endtask

  function automatic logic signed [31:0] rand_accel();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(131072)) - 65536;
      2: return $signed($urandom_range(4194304)) - 2097152;
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_range();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1 << 20);
      2: return 32'hFFFFFFFF - $urandom_range(1 << 16);
      default: return $urandom_range(64);
    endcase
  endfunction

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        send_item(1'b1, $signed($urandom), $signed($urandom), 16'($urandom_range(46079)),
                  rand_range(), 3'($urandom_range(7)));
      else if ($urandom_range(49) == 0)
        send_item(1'b1, $signed($urandom), $signed($urandom), 16'($urandom_range(65535)),
                  rand_range(), 3'($urandom_range(7)));
      else
        send_item(1'b0, rand_accel(), rand_accel(), 16'($urandom), $urandom,
                  3'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(1'b0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, '0, 16'd0, 32'd65536, 3'd7);
    send_item(1'b0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, '0, 16'd46079, 32'hFFFFFFFF, 3'd0);
    send_item(1'b0, 32'sh7fffffff, 32'sh80000000, 16'hFFFF, 32'hFFFFFFFF, 3'd7);
    send_item(1'b0, 32'sh7fffffff, 32'sh80000000, '0, '0, '0);
    send_item(1'b1, '0, '0, 16'hFFFF, 32'd1000000, 3'd5);
    send_item(1'b0, 32'sh80000000, 32'sh7fffffff, '0, '0, '0);
    send_item(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd46080, 32'd0, 3'd3);
    send_item(1'b0, '0, '0, '0, '0, '0);
    for (int s = 0; s < 8; s++) begin
      send_item(1'b1, '0, '0, 16'(11520 - s * 5760 + 46080 * (s > 2)), 32'd655360, 3'(s));
      send_item(1'b0, '0, '0, '0, '0, '0);
    end
    drain();

    write_period(16'd0);
    random_items(60);
    drain();
    write_period(16'hFFFF);
    random_items(60);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_period(16'($urandom_range(65535)));
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 32) : 0;
      stall_pct = (ph == 2) ? 88 : ((ph == 3) ? 32 : 0);
      random_items(370);
      drain();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    write_period(PeriodReset);
    hold_cycles = 400;
    random_items(20);
    drain();

    $display("Ran %0d transactions, %0d results checked, over several step periods", sent,
             board.checked);
    $display("including zero and full-scale periods, saturating accels and wrapped fixes.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: sim.f
design/drss_pkg.sv
design/drss_cordic.sv
design/dead_reckoning_sector_select_top.sv
verif/tb.sv
